/* rtl/core/wss_pkg.sv */
package wss_pkg;

  // Tree geometry
  localparam int LEAVES      = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int RAND_BITS   = 8;
  localparam int LEVELS      = $clog2(LEAVES);
  localparam int PAD         = 1 << LEVELS;
  localparam int NODE_BITS   = LEVELS + 1;
  localparam int ROW_BITS    = LEVELS;
  localparam int SUM_BITS    = WEIGHT_BITS + LEVELS;
  localparam int PROD_BITS   = RAND_BITS + SUM_BITS;
  localparam int LVL_BITS    = $clog2(LEVELS + 1);

  // Field widths
  localparam int ACTION_BITS = 2;
  localparam int LEAF_BITS   = 8;
  localparam int VALUE_BITS  = 16;
  localparam int RBITS_BITS  = 64;
  localparam int KIND_BITS   = 2;
  localparam int SAMPLE_BITS = 8;
  localparam int TOTAL_BITS  = 24;
  localparam int COUNT_BITS  = 9;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(256);

  // Action codes
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_DRAW  = 2'd2;

  // Result kinds
  localparam logic [KIND_BITS-1:0] KIND_CLEARED  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_WRITTEN  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_DRAWN    = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_REJECTED = 2'd3;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [LEAF_BITS-1:0]   leaf_index;
    logic [VALUE_BITS-1:0]  weight_value;
    logic [RBITS_BITS-1:0]  random_bits;
  } in_item_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [SAMPLE_BITS-1:0] sample_index;
    logic [TOTAL_BITS-1:0]  total_weight;
  } out_item_t;

  // One memory row holds both children of a node
  typedef struct packed {
    logic [SUM_BITS-1:0] right;
    logic [SUM_BITS-1:0] left;
  } pair_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk;
    logic last;
    logic out_busy;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/wss_ram.sv */
module wss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/wss_ctrl.sv */
module wss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  wss_pkg::dp_status_t status,
  output wss_pkg::ctrl_cmd_t  cmd
);
  import wss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.walk ? ST_STEP : ST_DONE;
        end
      end
      ST_STEP: begin
        if (status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.step = (state == ST_STEP);
    cmd.emit = (state == ST_DONE) && !status.out_busy;
  end

endmodule

/* rtl/core/wss_datapath.sv */
module wss_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [wss_pkg::COUNT_BITS-1:0]     cfg_data,
  input  wss_pkg::in_item_t                  in_item,
  input  wss_pkg::ctrl_cmd_t                 cmd,
  output wss_pkg::dp_status_t                status,
  input  logic                               out_stall,
  output logic                               out_valid,
  output wss_pkg::out_item_t                 out_item
);
  import wss_pkg::*;

  logic [COUNT_BITS-1:0] weight_count;
  logic [PAD-1:0]        valid;
  logic                  rd_valid;
  logic [SUM_BITS-1:0]   root;
  logic [LVL_BITS-1:0]   level;
  logic                  op_draw;
  logic [KIND_BITS-1:0]  kind;
  logic [NODE_BITS-1:0]  node;
  logic [NODE_BITS-1:0]  node_next;
  logic [SUM_BITS-1:0]   cur;
  logic [SUM_BITS-1:0]   cur_next;
  logic [RBITS_BITS-1:0] rnd;
  logic [RBITS_BITS-1:0] rnd_next;

  logic                  leaf_ok;
  logic                  clear_tree;
  logic                  draw_sel;
  logic [KIND_BITS-1:0]  kind_in;
  pair_t                 ram_rdata;
  pair_t                 pair_q;
  pair_t                 new_pair;
  logic [SUM_BITS-1:0]   cur_sum;
  logic [RAND_BITS-1:0]  frac;
  logic [PROD_BITS-1:0]  prod;
  logic                  go_left;
  logic                  we;
  logic [ROW_BITS-1:0]   waddr;
  logic [ROW_BITS-1:0]   raddr;

  assign leaf_ok = ({1'b0, in_item.leaf_index} < weight_count)
                && ({1'b0, in_item.leaf_index} < COUNT_BITS'(LEAVES));

  assign clear_tree = cfg_write || (cmd.load && (in_item.action == ACT_CLEAR));

  always_comb begin
    case (in_item.action)
      ACT_CLEAR: kind_in = KIND_CLEARED;
      ACT_WRITE: kind_in = leaf_ok ? KIND_WRITTEN : KIND_REJECTED;
      ACT_DRAW:  kind_in = KIND_DRAWN;
      default:   kind_in = KIND_REJECTED;
    endcase
  end

  assign status.walk     = (in_item.action == ACT_DRAW)
                        || ((in_item.action == ACT_WRITE) && leaf_ok);
  assign status.last     = (level == LVL_BITS'(LEVELS - 1));
  assign status.out_busy = out_valid && out_stall;

  // rows never written since the last clear read as zero
  assign pair_q = rd_valid ? ram_rdata : '0;

  // draw: go left when r * parent <= left * 2^RAND_BITS
  assign frac    = rnd[RAND_BITS-1:0];
  assign prod    = PROD_BITS'(frac) * PROD_BITS'(cur);
  assign go_left = (prod <= {pair_q.left, {RAND_BITS{1'b0}}});

  // write: replace this node's half of the row, sum gives the parent
  always_comb begin
    new_pair = pair_q;
    if (node[0]) begin
      new_pair.right = cur;
    end else begin
      new_pair.left = cur;
    end
  end

  assign cur_sum = new_pair.left + new_pair.right;

  always_comb begin
    node_next = node;
    cur_next  = cur;
    rnd_next  = rnd;
    if (cmd.load) begin
      rnd_next = in_item.random_bits;
      if (in_item.action == ACT_DRAW) begin
        node_next = NODE_BITS'(1);
        cur_next  = root;
      end else begin
        node_next = {1'b1, in_item.leaf_index[LEVELS-1:0]};
        cur_next  = SUM_BITS'(in_item.weight_value);
      end
    end else if (cmd.step) begin
      if (op_draw) begin
        node_next = {node[LEVELS-1:0], ~go_left};
        cur_next  = go_left ? pair_q.left : pair_q.right;
        rnd_next  = rnd >> RAND_BITS;
      end else begin
        node_next = node >> 1;
        cur_next  = cur_sum;
      end
    end
  end

  // next row is read while the current one is being updated
  assign draw_sel = cmd.load ? (in_item.action == ACT_DRAW) : op_draw;
  assign raddr    = draw_sel ? node_next[ROW_BITS-1:0] : node_next[LEVELS:1];
  assign we       = cmd.step && !op_draw;
  assign waddr    = node[LEVELS:1];

  wss_ram #(
    .WIDTH($bits(pair_t)),
    .DEPTH(PAD)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(new_pair),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_count <= COUNT_RESET;
      valid        <= '0;
      rd_valid     <= 1'b0;
      root         <= '0;
      level        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        weight_count <= cfg_data;
      end
      if (clear_tree) begin
        valid <= '0;
        root  <= '0;
      end else begin
        if (we) begin
          valid[waddr] <= 1'b1;
        end
        if (we && status.last) begin
          root <= cur_sum;
        end
      end
      rd_valid <= valid[raddr];
      if (cmd.load) begin
        level <= '0;
      end else if (cmd.step) begin
        level <= level + LVL_BITS'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    cur  <= cur_next;
    rnd  <= rnd_next;
    if (cmd.load) begin
      op_draw <= (in_item.action == ACT_DRAW);
      kind    <= kind_in;
    end
    if (cmd.emit) begin
      out_item.kind         <= kind;
      out_item.sample_index <= (kind == KIND_DRAWN)
                               ? SAMPLE_BITS'(node[LEVELS-1:0]) : '0;
      out_item.total_weight <= TOTAL_BITS'(root);
    end
  end

endmodule

/* rtl/core/weighted_sampler_sum_tree.sv */
// A write or draw walks one tree level a cycle, from leaf to root or from root to leaf, then
//   registers the result in out_valid/out_item; clear and rejected items skip the walk.
// No new item is taken (in_stall) until the current result has gone to the output register;
//   the node memory has a single read/write port pair, one row a level.
// Reset (rst, synchronous): tree reads as all zero at once (per-row valid flags cleared),
//   weight_count returns to 256, no result pending.
module weighted_sampler_sum_tree (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wss_pkg::COUNT_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wss_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wss_pkg::out_item_t             out_item
);
  import wss_pkg::*;

  // Structure
  //   wss_ctrl     : three-state sequencer (idle / walk a level / hand over result).
  //   wss_datapath : node memory, walk registers, compare and adder, output register.
  //
  // Tree storage
  //   Node sums sit in one memory row per parent: row n holds the sums of
  //   children 2n and 2n+1, so a draw gets both candidates in one read and a
  //   write gets the sibling it needs. The root sum is a register of its own.
  //   Each row has a valid flag; clear items and weight_count writes drop all
  //   flags together, so no sweep of the memory is needed.
  //
  // Walks
  //   Write: starts at the leaf, at each level replaces its half of the row,
  //   writes the row back and carries the pair sum up; the read of the next
  //   row up is issued in the same cycle. The final sum lands in the root.
  //   Draw: starts at the root, compares r * parent against left << RAND_BITS
  //   exactly (8 x 24 bit product), steps to the chosen child and issues the
  //   read of that child's row. Random fraction shifts down one byte a level.
  //
  // Output
  //   The result item waits in an output register; the next input item is
  //   taken while it waits, and the sequencer only holds in its last state
  //   when a fresh result is ready and the register is still stalled.

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  wss_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
